// ===== sv/sne_pkg.sv =====
`timescale 1ns / 1ps
// sne_pkg: shared types, codes and constants of the sobel edge stream
// no dependencies

package sne_pkg;

	// field widths
	localparam int CFG_W    = 11;
	localparam int GRAY_W   = 8;
	localparam int CHAN_W   = 8;
	localparam int MAG_W    = 11;
	localparam int DIR_W    = 2;
	localparam int STR_W    = 2;
	localparam int GRAD_W   = 12;
	localparam int ENERGY_W = 22;

	// default frame limits
	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int MAX_HEIGHT_DEF = 1024;
	localparam int DIM_MIN        = 3;

	// register reset values
	localparam logic [CFG_W-1:0] IMAGE_WIDTH_RST  = 11'd640;
	localparam logic [CFG_W-1:0] IMAGE_HEIGHT_RST = 11'd480;
	localparam logic [CFG_W-1:0] LOW_THR_RST      = 11'd75;
	localparam logic [CFG_W-1:0] HIGH_THR_RST     = 11'd150;

	// register indexes
	localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
	localparam logic [1:0] REG_LOW_THR      = 2'd2;
	localparam logic [1:0] REG_HIGH_THR     = 2'd3;

	// item kinds
	localparam logic KIND_PIXEL = 1'b0;
	localparam logic KIND_DRAIN = 1'b1;

	// direction codes
	localparam logic [DIR_W-1:0] DIR_HORZ   = 2'd0;
	localparam logic [DIR_W-1:0] DIR_DIAG45 = 2'd1;
	localparam logic [DIR_W-1:0] DIR_VERT   = 2'd2;
	localparam logic [DIR_W-1:0] DIR_DIAG135 = 2'd3;

	// strength codes
	localparam logic [STR_W-1:0] STR_NONE   = 2'd0;
	localparam logic [STR_W-1:0] STR_WEAK   = 2'd1;
	localparam logic [STR_W-1:0] STR_STRONG = 2'd2;

	// gray = sum * 683 >> 11 equals sum / 3 for every sum up to 765
	localparam int GRAY_RECIP = 683;
	localparam int GRAY_SHIFT = 11;

	// q12 tangents of 22.5 and 67.5 degrees
	localparam int TAN_LO_Q12 = 1697;
	localparam int TAN_HI_Q12 = 9889;
	localparam int Q12_SHIFT  = 12;

	// square root unit
	localparam int ROOT_STEPS = 11;

	// 3x3 window taps in order nw, n, ne, w, e, sw, s, se
	localparam logic [2:0] TAP_LAST = 3'd7;
	localparam logic signed [2:0] SOBEL_X [0:7] = '{-3'sd1, 3'sd0, 3'sd1, -3'sd2,
		3'sd2, -3'sd1, 3'sd0, 3'sd1};
	localparam logic signed [2:0] SOBEL_Y [0:7] = '{-3'sd1, -3'sd2, -3'sd1, 3'sd0,
		3'sd0, 3'sd1, 3'sd2, 3'sd1};

	// sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_GSTART,
		ST_GRD,
		ST_GACC,
		ST_SQS,
		ST_SQ,
		ST_GWR,
		ST_ERC,
		ST_EC,
		ST_EN1,
		ST_EN2,
		ST_EOUT
	} sne_state_t;

endpackage

// ===== sv/sne_ram.sv =====
`timescale 1ns / 1ps
// sne_ram: generic simple dual-port ram, one write and one registered read
// no dependencies

module sne_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2052
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== sv/sne_isqrt.sv =====
`timescale 1ns / 1ps
// sne_isqrt: iterative floor square root, one result bit per cycle
// depends on sne_pkg

module sne_isqrt
	import sne_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [ENERGY_W-1:0] energy,
	output logic                done,
	output logic [MAG_W-1:0]    root
);

	localparam int STEP_W = $clog2(ROOT_STEPS);

	logic [ENERGY_W-1:0] rem_q, root_q, bit_q, trial;
	logic [STEP_W-1:0]   step_q;
	logic                busy_q, done_q;

	assign trial = root_q + bit_q;

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				if (step_q == STEP_W'(ROOT_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					step_q <= step_q + 1'b1;
				end
			end
		end
	end

	// remainder and root datapath
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= energy;
			root_q <= '0;
			bit_q  <= ENERGY_W'(1) << (ENERGY_W - 2);
		end else if (busy_q) begin
			if (rem_q >= trial) begin
				rem_q  <= rem_q - trial;
				root_q <= (root_q >> 1) + bit_q;
			end else begin
				root_q <= root_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign done = done_q;
	assign root = root_q[MAG_W-1:0];

endmodule

// ===== sv/sobel_nonmax_edge_stream.sv =====
`timescale 1ns / 1ps
// sobel_nonmax_edge_stream: gray conversion, sobel gradient, root, direction and
// non-maximum suppression over two line-store rams; depends on sne_pkg, sne_ram, sne_isqrt
//
//  channel  direction  handshake            payload
//  in       sink       in_valid/in_ready    kind, red, green, blue
//  out      source     out_valid/out_ready  edge_res, strength, magnitude, direction, end_of_frame
//  cfg      sink       cfg_valid/cfg_ready  cfg_index, cfg_data
//
// one word at a time: a pixel with no gradient due is only stored, a border gradient
// stores a zero magnitude, an interior gradient takes eight gray reads, one per window tap, then
// the 11-step root unit, and a result adds magnitude ram reads of its centre and, off the border, two neighbours.
// reset clears counters and control; the rams are never cleared and are written before read.
// a result held by out_ready low stalls only the word that produces the next result.
// cfg is always ready.

module sobel_nonmax_edge_stream
	import sne_pkg::*;
#(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              kind,
	input  logic [CHAN_W-1:0] red,
	input  logic [CHAN_W-1:0] green,
	input  logic [CHAN_W-1:0] blue,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              edge_res,
	output logic [STR_W-1:0]  strength,
	output logic [MAG_W-1:0]  magnitude,
	output logic [DIR_W-1:0]  direction,
	output logic              end_of_frame,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [CFG_W-1:0]  cfg_data
);

	localparam int RING  = 2 * MAX_WIDTH + 4;
	localparam int AW    = $clog2(RING);
	localparam int WDW   = $clog2(MAX_WIDTH + 1);
	localparam int HDW   = $clog2(MAX_HEIGHT + 1);
	localparam int CLW   = $clog2(MAX_WIDTH);
	localparam int POS_W = $clog2(MAX_WIDTH * MAX_HEIGHT);
	localparam int QC_W  = POS_W + 2;
	localparam int CWW   = (WDW > CFG_W) ? WDW : CFG_W;
	localparam int CHW   = (HDW > CFG_W) ? HDW : CFG_W;
	localparam int W_RST = (int'(IMAGE_WIDTH_RST) > MAX_WIDTH) ? MAX_WIDTH
		: int'(IMAGE_WIDTH_RST);
	localparam int H_RST = (int'(IMAGE_HEIGHT_RST) > MAX_HEIGHT) ? MAX_HEIGHT
		: int'(IMAGE_HEIGHT_RST);
	localparam int MD_W  = MAG_W + DIR_W;

	// ring address plus or minus an offset below the ring size
	function automatic logic [AW-1:0] ring_off(input logic [AW-1:0] base,
		input logic [AW-1:0] off, input logic neg);
		logic [AW:0] s;
		if (neg) begin
			s = {1'b0, base} - {1'b0, off};
			if (s[AW]) begin
				s = s + (AW+1)'(RING);
			end
		end else begin
			s = {1'b0, base} + {1'b0, off};
			if (s >= (AW+1)'(RING)) begin
				s = s - (AW+1)'(RING);
			end
		end
		return s[AW-1:0];
	endfunction

	function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] a);
		return (a == AW'(RING - 1)) ? '0 : a + 1'b1;
	endfunction

	function automatic logic [WDW-1:0] clamp_w(input logic [CFG_W-1:0] v);
		logic [CWW-1:0] e;
		e = CWW'(v);
		if (e < CWW'(DIM_MIN)) return WDW'(DIM_MIN);
		if (e > CWW'(MAX_WIDTH)) return WDW'(MAX_WIDTH);
		return WDW'(e);
	endfunction

	function automatic logic [HDW-1:0] clamp_h(input logic [CFG_W-1:0] v);
		logic [CHW-1:0] e;
		e = CHW'(v);
		if (e < CHW'(DIM_MIN)) return HDW'(DIM_MIN);
		if (e > CHW'(MAX_HEIGHT)) return HDW'(MAX_HEIGHT);
		return HDW'(e);
	endfunction

	// configuration registers
	logic [CFG_W-1:0] image_width_q, image_height_q, low_thr_q, high_thr_q;

	// frame geometry and position counters
	logic [WDW-1:0]   frame_w_q;
	logic [HDW-1:0]   frame_h_q;
	logic [HDW-1:0]   in_row_q, m_row_q, p_row_q;
	logic [CLW-1:0]   in_col_q, m_col_q, p_col_q;
	logic [POS_W-1:0] q_pos_q;
	logic [AW-1:0]    qa_q, ma_q, pa_q;
	logic             emit_q;
	logic [2:0]       tap_q;
	sne_state_t       state_q, state_d;

	// datapath registers
	logic signed [GRAD_W-1:0] gx_q, gy_q;
	logic [MAG_W-1:0]         mag_c_q, n1_q;
	logic [DIR_W-1:0]         dir_c_q;
	logic                     edge_q;
	logic                     out_valid_q;
	logic                     edge_res_q, end_of_frame_q;
	logic [STR_W-1:0]         strength_q;
	logic [MAG_W-1:0]         magnitude_q;
	logic [DIR_W-1:0]         direction_q;

	// ram ports
	logic              g_we, md_we;
	logic [AW-1:0]     g_waddr, g_raddr, md_waddr, md_raddr;
	logic [GRAY_W-1:0] g_wdata, g_rdata;
	logic [MD_W-1:0]   md_wdata, md_rdata;

	// strobes
	logic pix_go, drain_go, grad_done, emit_go, sq_start, sq_done;
	logic acc_en, cap_c, cap_n1, cap_n2;

	// derived values
	logic              frame_start, full, m_live, m_border, p_border, p_eof;
	logic [WDW-1:0]    fw_now;
	logic [HDW-1:0]    fh_now;
	logic [CLW-1:0]    fw_last, fwn_last;
	logic [HDW-1:0]    fh_last;
	logic [QC_W-1:0]   q_ext;
	logic              need_grad, need_emit;
	logic [9:0]        chan_sum;
	logic [19:0]       gray_prod;
	logic [GRAY_W-1:0] gray_new;
	logic [AW-1:0]     tap_off, w_ext, nb_off_rd, nb_off_q;
	logic [AW-1:0]     tap_addr;
	logic [MAG_W-1:0]  ax, ay, sq_root;
	logic [ENERGY_W-1:0] energy;
	logic [25:0]       ay_q12, ax_lo, ax_hi;
	logic [DIR_W-1:0]  dir_new;
	logic signed [GRAD_W-1:0] tap_val, wx12, wy12;
	logic [MAG_W-1:0]  n2_rd, mag_rd;
	logic [STR_W-1:0]  str_new;

	// frame bookkeeping
	assign frame_start = (in_row_q == '0) && (in_col_q == '0) && (p_row_q == '0)
		&& (p_col_q == '0);
	assign fw_now   = frame_start ? clamp_w(image_width_q) : frame_w_q;
	assign fh_now   = frame_start ? clamp_h(image_height_q) : frame_h_q;
	assign fwn_last = CLW'(fw_now - 1'b1);
	assign fw_last  = CLW'(frame_w_q - 1'b1);
	assign fh_last  = frame_h_q - 1'b1;
	assign full     = (in_row_q >= frame_h_q);
	assign m_live   = (m_row_q < frame_h_q);
	assign m_border = (m_row_q == '0) || (m_row_q == fh_last) || (m_col_q == '0)
		|| (m_col_q == fw_last);
	assign p_border = (p_row_q == '0) || (p_row_q == fh_last) || (p_col_q == '0)
		|| (p_col_q == fw_last);
	assign p_eof    = (p_row_q == fh_last) && (p_col_q == fw_last);
	assign q_ext     = QC_W'(q_pos_q);
	assign need_grad = q_ext >= (QC_W'(fw_now) + QC_W'(1));
	assign need_emit = q_ext >= ((QC_W'(fw_now) << 1) + QC_W'(2));

	// gray by reciprocal multiply
	assign chan_sum  = 10'(red) + 10'(green) + 10'(blue);
	assign gray_prod = 20'(chan_sum) * 20'(GRAY_RECIP);
	assign gray_new  = gray_prod[GRAY_SHIFT +: GRAY_W];

	// window tap addresses around the gradient position
	assign w_ext = AW'(frame_w_q);
	always_comb begin
		case (tap_q) inside
			3'd0, 3'd7: tap_off = w_ext + 1'b1;
			3'd1, 3'd6: tap_off = w_ext;
			3'd2, 3'd5: tap_off = w_ext - 1'b1;
			default:    tap_off = AW'(1);
		endcase
	end
	assign tap_addr = ring_off(ma_q, tap_off, ~tap_q[2]);

	// neighbour distance along the gradient axis
	function automatic logic [AW-1:0] nb_off(input logic [DIR_W-1:0] d,
		input logic [AW-1:0] w);
		logic [AW-1:0] r;
		unique case (d)
			DIR_HORZ:   r = AW'(1);
			DIR_DIAG45: r = w + 1'b1;
			DIR_VERT:   r = w;
			DIR_DIAG135: r = w - 1'b1;
		endcase
		return r;
	endfunction

	assign mag_rd    = md_rdata[MD_W-1 -: MAG_W];
	assign n2_rd     = mag_rd;
	assign nb_off_rd = nb_off(md_rdata[DIR_W-1:0], w_ext);
	assign nb_off_q  = nb_off(dir_c_q, w_ext);

	// tap weighting
	assign tap_val = GRAD_W'(signed'({1'b0, g_rdata}));
	assign wx12    = GRAD_W'(SOBEL_X[tap_q]);
	assign wy12    = GRAD_W'(SOBEL_Y[tap_q]);

	// magnitude inputs and direction quantisation
	assign ax      = gx_q[GRAD_W-1] ? MAG_W'(-gx_q) : MAG_W'(gx_q);
	assign ay      = gy_q[GRAD_W-1] ? MAG_W'(-gy_q) : MAG_W'(gy_q);
	assign energy  = ENERGY_W'(ax) * ENERGY_W'(ax) + ENERGY_W'(ay) * ENERGY_W'(ay);
	assign ay_q12  = 26'(ay) << Q12_SHIFT;
	assign ax_lo   = 26'(ax) * 26'(TAN_LO_Q12);
	assign ax_hi   = 26'(ax) * 26'(TAN_HI_Q12);
	always_comb begin
		if (ay_q12 <= ax_lo) begin
			dir_new = DIR_HORZ;
		end else if (ay_q12 > ax_hi) begin
			dir_new = DIR_VERT;
		end else if (gx_q[GRAD_W-1] == gy_q[GRAD_W-1]) begin
			dir_new = DIR_DIAG45;
		end else begin
			dir_new = DIR_DIAG135;
		end
	end

	// threshold classes
	always_comb begin
		if (mag_c_q > high_thr_q) begin
			str_new = STR_STRONG;
		end else if (mag_c_q > low_thr_q) begin
			str_new = STR_WEAK;
		end else begin
			str_new = STR_NONE;
		end
	end

	// sequencer next state and ram control
	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		g_we      = 1'b0;
		g_waddr   = qa_q;
		g_wdata   = gray_new;
		g_raddr   = tap_addr;
		md_we     = 1'b0;
		md_waddr  = ma_q;
		md_wdata  = {sq_root, dir_new};
		md_raddr  = pa_q;
		pix_go    = 1'b0;
		drain_go  = 1'b0;
		grad_done = 1'b0;
		emit_go   = 1'b0;
		sq_start  = 1'b0;
		acc_en    = 1'b0;
		cap_c     = 1'b0;
		cap_n1    = 1'b0;
		cap_n2    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (kind == KIND_PIXEL && !full) begin
						g_we   = 1'b1;
						pix_go = 1'b1;
						if (need_grad) begin
							state_d = ST_GSTART;
						end
					end else if (kind == KIND_DRAIN && full) begin
						drain_go = 1'b1;
						state_d  = m_live ? ST_GSTART : ST_ERC;
					end
				end
			end
			ST_GSTART: begin
				if (m_border) begin
					md_we     = 1'b1;
					md_wdata  = '0;
					grad_done = 1'b1;
					state_d   = emit_q ? ST_ERC : ST_IDLE;
				end else begin
					state_d = ST_GRD;
				end
			end
			ST_GRD: begin
				state_d = ST_GACC;
			end
			ST_GACC: begin
				acc_en  = 1'b1;
				state_d = (tap_q == TAP_LAST) ? ST_SQS : ST_GRD;
			end
			ST_SQS: begin
				sq_start = 1'b1;
				state_d  = ST_SQ;
			end
			ST_SQ: begin
				if (sq_done) begin
					state_d = ST_GWR;
				end
			end
			ST_GWR: begin
				md_we     = 1'b1;
				grad_done = 1'b1;
				state_d   = emit_q ? ST_ERC : ST_IDLE;
			end
			ST_ERC: begin
				state_d = ST_EC;
			end
			ST_EC: begin
				cap_c = 1'b1;
				if (p_border) begin
					state_d = ST_EOUT;
				end else begin
					md_raddr = ring_off(pa_q, nb_off_rd, 1'b1);
					state_d  = ST_EN1;
				end
			end
			ST_EN1: begin
				cap_n1   = 1'b1;
				md_raddr = ring_off(pa_q, nb_off_q, 1'b0);
				state_d  = ST_EN2;
			end
			ST_EN2: begin
				cap_n2  = 1'b1;
				state_d = ST_EOUT;
			end
			ST_EOUT: begin
				if (!out_valid_q || out_ready) begin
					emit_go = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration writes
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= IMAGE_WIDTH_RST;
			image_height_q <= IMAGE_HEIGHT_RST;
			low_thr_q      <= LOW_THR_RST;
			high_thr_q     <= HIGH_THR_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH:  image_width_q  <= cfg_data;
				REG_IMAGE_HEIGHT: image_height_q <= cfg_data;
				REG_LOW_THR:      low_thr_q      <= cfg_data;
				REG_HIGH_THR:     high_thr_q     <= cfg_data;
			endcase
		end
	end

	// position counters and ring pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_w_q <= WDW'(W_RST);
			frame_h_q <= HDW'(H_RST);
			in_row_q  <= '0;
			in_col_q  <= '0;
			q_pos_q   <= '0;
			qa_q      <= '0;
			m_row_q   <= '0;
			m_col_q   <= '0;
			ma_q      <= '0;
			p_row_q   <= '0;
			p_col_q   <= '0;
			pa_q      <= '0;
			emit_q    <= 1'b0;
			tap_q     <= '0;
		end else begin
			if (pix_go) begin
				frame_w_q <= fw_now;
				frame_h_q <= fh_now;
				emit_q    <= need_emit;
				q_pos_q   <= q_pos_q + 1'b1;
				qa_q      <= ring_inc(qa_q);
				if (in_col_q == fwn_last) begin
					in_col_q <= '0;
					in_row_q <= in_row_q + 1'b1;
				end else begin
					in_col_q <= in_col_q + 1'b1;
				end
			end
			if (drain_go) begin
				emit_q <= 1'b1;
			end
			if (state_q == ST_GSTART) begin
				tap_q <= '0;
			end else if (acc_en) begin
				tap_q <= tap_q + 1'b1;
			end
			if (grad_done) begin
				ma_q <= ring_inc(ma_q);
				if (m_col_q == fw_last) begin
					m_col_q <= '0;
					m_row_q <= m_row_q + 1'b1;
				end else begin
					m_col_q <= m_col_q + 1'b1;
				end
			end
			if (emit_go) begin
				if (p_eof) begin
					in_row_q <= '0;
					in_col_q <= '0;
					q_pos_q  <= '0;
					qa_q     <= '0;
					m_row_q  <= '0;
					m_col_q  <= '0;
					ma_q     <= '0;
					p_row_q  <= '0;
					p_col_q  <= '0;
					pa_q     <= '0;
				end else begin
					pa_q <= ring_inc(pa_q);
					if (p_col_q == fw_last) begin
						p_col_q <= '0;
						p_row_q <= p_row_q + 1'b1;
					end else begin
						p_col_q <= p_col_q + 1'b1;
					end
				end
			end
		end
	end

	// gradient accumulation and neighbour capture
	always_ff @(posedge clk) begin
		if (state_q == ST_GSTART) begin
			gx_q <= '0;
			gy_q <= '0;
		end else if (acc_en) begin
			gx_q <= gx_q + GRAD_W'(wx12 * tap_val);
			gy_q <= gy_q + GRAD_W'(wy12 * tap_val);
		end
		if (cap_c) begin
			mag_c_q <= mag_rd;
			dir_c_q <= md_rdata[DIR_W-1:0];
			edge_q  <= 1'b0;
		end
		if (cap_n1) begin
			n1_q <= mag_rd;
		end
		if (cap_n2) begin
			edge_q <= (mag_c_q > n1_q) && (mag_c_q > n2_rd);
		end
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_go) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_go) begin
			edge_res_q     <= edge_q;
			strength_q     <= str_new;
			magnitude_q    <= mag_c_q;
			direction_q    <= dir_c_q;
			end_of_frame_q <= p_eof;
		end
	end

	assign out_valid    = out_valid_q;
	assign edge_res     = edge_res_q;
	assign strength     = strength_q;
	assign magnitude    = magnitude_q;
	assign direction    = direction_q;
	assign end_of_frame = end_of_frame_q;

	// gray line store
	sne_ram #(
		.WIDTH (GRAY_W),
		.DEPTH (RING)
	) u_gray_ram (
		.clk   (clk),
		.we    (g_we),
		.waddr (g_waddr),
		.wdata (g_wdata),
		.raddr (g_raddr),
		.rdata (g_rdata)
	);

	// magnitude and direction line store
	sne_ram #(
		.WIDTH (MD_W),
		.DEPTH (RING)
	) u_md_ram (
		.clk   (clk),
		.we    (md_we),
		.waddr (md_waddr),
		.wdata (md_wdata),
		.raddr (md_raddr),
		.rdata (md_rdata)
	);

	// magnitude root
	sne_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_start),
		.energy (energy),
		.done   (sq_done),
		.root   (sq_root)
	);

`ifndef NO_ASSERTIONS
	// a new output word only comes from the output state
	a_out_from_eout: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_EOUT)
		else $error("output word loaded outside the output state");

	// the root unit finishes only while the sequencer waits for it
	a_root_wait: assert property (@(posedge clk) disable iff (!arst_n)
		sq_done |-> state_q == ST_SQ)
		else $error("root result arrived while sequencer not waiting");

	// the frame's last result returns every counter to the frame start
	a_eof_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_go && p_eof) |=> (in_row_q == '0 && q_pos_q == '0 && p_row_q == '0
		&& p_col_q == '0 && m_row_q == '0))
		else $error("counters not cleared after end of frame");
`endif

endmodule
